// File: sv/cfpp_pkg.sv
// shared constants, command/status structs and the crc byte update
// for the crc16 framed packet parser; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfpp_pkg;

  localparam int MAX_FRAME_LEN = 17;
  localparam int LEN_LIMIT     = (MAX_FRAME_LEN < 17) ? MAX_FRAME_LEN : 17;
  localparam logic [9:0] LEN_LIMIT_W = 10'(LEN_LIMIT);

  localparam logic [7:0]  START_BYTE = 8'hAA;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  localparam int DATA_DEPTH = 16;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic crc_start;
    logic crc_upd;
    logic ld_flo;
    logic ld_len;
    logic clr_cnt;
    logic wr_data;
    logic ld_clo;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic ld_single;
    logic ld_data;
    logic out_clr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_start;
    logic len_bad;
    logic len_one;
    logic id_match;
    logic data_done;
    logic crc_ok;
    logic out_valid;
    logic out_last;
  } sts_t;

  // crc-16/xmodem, one byte msb first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/crc16_framed_packet_parser_top.sv
// a byte is taken every cycle while a frame is parsed; an error or empty result is
// valid the cycle after the crc high byte, the first data result after read and load
// states; each data result is a store read, a load and a handoff, the next read waiting
// for a take; input stalls from the crc high byte until the frame's last result is taken
// reset: synchronous active low, clears the phase, the id register and the output valid
// top level; depends on cfpp_pkg, cfpp_ctrl, cfpp_dp
`timescale 1ns / 1ps
`default_nettype none

module crc16_framed_packet_parser_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_status,
  output logic [7:0]      out_frame_id,
  output logic [7:0]      out_payload_byte,
  output logic [3:0]      out_byte_index,
  output logic [4:0]      out_payload_count,
  output logic            out_last,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  cfpp_pkg::cmd_t cmd;
  cfpp_pkg::sts_t sts;

  cfpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfpp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_frame_id     (out_frame_id),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_payload_count(out_payload_count),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// File: sv/cfpp_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cfpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/cfpp_ctrl.sv
// parser controller: frame phase sequencing and result emission
// depends on cfpp_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfpp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           out_ready,
  input  wire cfpp_pkg::sts_t sts,
  output cfpp_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_HUNT = 4'd0;
  localparam logic [3:0] S_FLO  = 4'd1;
  localparam logic [3:0] S_FHI  = 4'd2;
  localparam logic [3:0] S_ID   = 4'd3;
  localparam logic [3:0] S_DATA = 4'd4;
  localparam logic [3:0] S_CLO  = 4'd5;
  localparam logic [3:0] S_CHI  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_LD   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_ready = (state_r inside {S_HUNT, S_FLO, S_FHI, S_ID, S_DATA, S_CLO, S_CHI});
  assign in_acc   = in_valid & in_ready;
  assign out_acc  = sts.out_valid & out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HUNT: begin
        if (in_acc && sts.is_start) begin
          cmd.crc_start = 1'b1;
          state_nxt     = S_FLO;
        end
      end
      S_FLO: begin
        if (in_acc) begin
          cmd.ld_flo  = 1'b1;
          cmd.crc_upd = 1'b1;
          state_nxt   = S_FHI;
        end
      end
      S_FHI: begin
        if (in_acc) begin
          cmd.ld_len  = 1'b1;
          cmd.crc_upd = 1'b1;
          state_nxt   = sts.len_bad ? S_HUNT : S_ID;
        end
      end
      S_ID: begin
        if (in_acc) begin
          if (sts.id_match) begin
            cmd.crc_upd = 1'b1;
            cmd.clr_cnt = 1'b1;
            state_nxt   = sts.len_one ? S_CLO : S_DATA;
          end else begin
            state_nxt = S_HUNT;
          end
        end
      end
      S_DATA: begin
        if (in_acc) begin
          cmd.wr_data = 1'b1;
          cmd.crc_upd = 1'b1;
          if (sts.data_done) begin
            state_nxt = S_CLO;
          end
        end
      end
      S_CLO: begin
        if (in_acc) begin
          cmd.ld_clo = 1'b1;
          state_nxt  = S_CHI;
        end
      end
      S_CHI: begin
        if (in_acc) begin
          // good crc with data bytes: walk the store, otherwise one result
          if (sts.crc_ok && !sts.len_one) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_RD;
          end else begin
            cmd.ld_single = 1'b1;
            state_nxt     = S_OUT;
          end
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.ld_data = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          cmd.out_clr = 1'b1;
          if (sts.out_last) begin
            state_nxt = S_HUNT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/cfpp_dp.sv
// parser datapath: crc, frame fields, data store and result register
// depends on cfpp_pkg and cfpp_ram
`timescale 1ns / 1ps
`default_nettype none

module cfpp_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     in_rx_byte,
  input  wire logic           cfg_wr_en,
  input  wire logic [7:0]     cfg_wr_data,
  input  wire cfpp_pkg::cmd_t cmd,
  output cfpp_pkg::sts_t      sts,
  output logic                out_valid,
  output logic                out_status,
  output logic [7:0]          out_frame_id,
  output logic [7:0]          out_payload_byte,
  output logic [3:0]          out_byte_index,
  output logic [4:0]          out_payload_count,
  output logic                out_last
);

  logic [7:0]  wanted_id_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  flo_r;
  logic [4:0]  len_r;
  logic [cfpp_pkg::DATA_AW-1:0] cnt_r;
  logic [7:0]  clo_r;
  logic [cfpp_pkg::DATA_AW-1:0] idx_r;
  logic [7:0]  ram_rdata;

  logic        out_valid_r;
  logic        out_status_r;
  logic [7:0]  out_frame_id_r;
  logic [7:0]  out_payload_byte_r;
  logic [3:0]  out_byte_index_r;
  logic [4:0]  out_payload_count_r;
  logic        out_last_r;

  logic [9:0]  len_w;
  logic [4:0]  pay_cnt;
  logic [15:0] rx_crc;

  assign len_w   = {in_rx_byte, flo_r[7:6]};
  assign pay_cnt = len_r - 5'd1;
  assign rx_crc  = {in_rx_byte, clo_r};

  assign sts.is_start  = (in_rx_byte == cfpp_pkg::START_BYTE);
  assign sts.len_bad   = (len_w == 10'd0) || (len_w > cfpp_pkg::LEN_LIMIT_W);
  assign sts.len_one   = (len_r == 5'd1);
  assign sts.id_match  = (in_rx_byte == wanted_id_r);
  // count after this write plus the id byte reaches the length
  assign sts.data_done = ({1'b0, cnt_r} + 5'd2) >= len_r;
  assign sts.crc_ok    = (rx_crc == crc_r);
  assign sts.out_valid = out_valid_r;
  assign sts.out_last  = out_last_r;

  always_comb begin
    crc_nxt = crc_r;
    if (cmd.crc_start) begin
      crc_nxt = cfpp_pkg::crc_add(16'h0000, in_rx_byte);
    end else if (cmd.crc_upd) begin
      crc_nxt = cfpp_pkg::crc_add(crc_r, in_rx_byte);
    end
  end

  cfpp_ram #(
    .WIDTH(8),
    .DEPTH(cfpp_pkg::DATA_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_data),
    .waddr(cnt_r),
    .wdata(in_rx_byte),
    .re   (cmd.rd_en),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_id_r <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wanted_id_r <= cfg_wr_data;
      end
      if (cmd.ld_single || cmd.ld_data) begin
        out_valid_r <= 1'b1;
      end else if (cmd.out_clr) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (cmd.ld_flo) begin
      flo_r <= in_rx_byte;
    end
    if (cmd.ld_len) begin
      len_r <= len_w[4:0];
    end
    if (cmd.clr_cnt) begin
      cnt_r <= '0;
    end else if (cmd.wr_data) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.ld_clo) begin
      clo_r <= in_rx_byte;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.ld_single) begin
      out_status_r        <= sts.crc_ok ? cfpp_pkg::STATUS_OK : cfpp_pkg::STATUS_ERR;
      out_frame_id_r      <= wanted_id_r;
      out_payload_byte_r  <= 8'h00;
      out_byte_index_r    <= 4'd0;
      out_payload_count_r <= pay_cnt;
      out_last_r          <= 1'b1;
    end else if (cmd.ld_data) begin
      out_status_r        <= cfpp_pkg::STATUS_OK;
      out_frame_id_r      <= wanted_id_r;
      out_payload_byte_r  <= ram_rdata;
      out_byte_index_r    <= idx_r;
      out_payload_count_r <= pay_cnt;
      out_last_r          <= (({1'b0, idx_r} + 5'd1) == pay_cnt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_id      = out_frame_id_r;
  assign out_payload_byte  = out_payload_byte_r;
  assign out_byte_index    = out_byte_index_r;
  assign out_payload_count = out_payload_count_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// File: bench/cfpp_result_checker.sv
`timescale 1ns / 1ps
// result checker for the crc16 framed packet parser: follows the byte and
// result channels, predicts each frame's result words and compares them
// depends on cfpp_pkg for the start byte, crc polynomial, length limit and status codes

module cfpp_result_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       out_status,
  input  wire logic [7:0] out_frame_id,
  input  wire logic [7:0] out_payload_byte,
  input  wire logic [3:0] out_byte_index,
  input  wire logic [4:0] out_payload_count,
  input  wire logic       out_last,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  output int              fail_count,
  output int              pending,
  output logic            hunting
);

  typedef enum logic [2:0] {
    SEEK, HDR_LO, HDR_HI, MSG_ID, DATA, CRC_LO, CRC_HI
  } parse_t;

  typedef struct packed {
    logic       status;
    logic [7:0] frame_id;
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic [4:0] payload_count;
    logic       last;
  } frame_word_t;

  parse_t      phase;
  logic [15:0] crc_acc;
  logic [7:0]  flo_byte;
  logic [9:0]  flen;
  logic [4:0]  dcount;
  logic [7:0]  crc_lo;
  logic [7:0]  want_id;
  logic [7:0]  data_mem [16];
  frame_word_t owed_words[$];
  frame_word_t seen, owed;
  int          errs = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    hunting    = 1'b1;
  end

  // bit-serial xmodem update, msb of the byte first
  function automatic logic [15:0] xmodem_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    int          i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ cfpp_pkg::CRC_POLY;
    end
    return c;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [4:0] cnt;
    int         k;
    case (phase)
      SEEK: begin
        if (b == cfpp_pkg::START_BYTE) begin
          crc_acc = xmodem_step(16'h0000, b);
          phase   = HDR_LO;
        end
      end
      HDR_LO: begin
        flo_byte = b;
        crc_acc  = xmodem_step(crc_acc, b);
        phase    = HDR_HI;
      end
      HDR_HI: begin
        flen    = {b, flo_byte[7:6]};
        crc_acc = xmodem_step(crc_acc, b);
        if (flen == 10'd0 || flen > cfpp_pkg::LEN_LIMIT_W) begin
          phase   = SEEK;
          crc_acc = 16'h0000;
        end else begin
          phase = MSG_ID;
        end
      end
      MSG_ID: begin
        if (b != want_id) begin
          phase   = SEEK;
          crc_acc = 16'h0000;
        end else begin
          crc_acc = xmodem_step(crc_acc, b);
          dcount  = 5'd0;
          phase   = (flen > 10'd1) ? DATA : CRC_LO;
        end
      end
      DATA: begin
        data_mem[dcount[3:0]] = b;
        crc_acc = xmodem_step(crc_acc, b);
        dcount  = dcount + 5'd1;
        if (10'(dcount) + 10'd1 >= flen) phase = CRC_LO;
      end
      CRC_LO: begin
        crc_lo = b;
        phase  = CRC_HI;
      end
      CRC_HI: begin
        cnt = 5'(flen - 10'd1);
        if ({b, crc_lo} != crc_acc) begin
          owed_words.push_back('{cfpp_pkg::STATUS_ERR, want_id, 8'h00, 4'd0, cnt, 1'b1});
        end else if (cnt == 5'd0) begin
          // id-only frame gives one empty word
          owed_words.push_back('{cfpp_pkg::STATUS_OK, want_id, 8'h00, 4'd0, 5'd0, 1'b1});
        end else begin
          for (k = 0; k < int'(cnt); k++)
            owed_words.push_back('{cfpp_pkg::STATUS_OK, want_id, data_mem[k], 4'(k), cnt,
                                   k == int'(cnt) - 1});
        end
        phase   = SEEK;
        crc_acc = 16'h0000;
        dcount  = 5'd0;
      end
      default: begin
        phase   = SEEK;
        crc_acc = 16'h0000;
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase    = SEEK;
      crc_acc  = 16'h0000;
      flo_byte = 8'h00;
      flen     = 10'd0;
      dcount   = 5'd0;
      crc_lo   = 8'h00;
      want_id  = 8'h00;
      owed_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = '{out_status, out_frame_id, out_payload_byte, out_byte_index,
                 out_payload_count, out_last};
        if (owed_words.size() == 0) begin
          $display("%0t ns: result word with nothing owed, expected none, got 0x%0h",
                   $time, seen);
          errs++;
        end else begin
          owed = owed_words.pop_front();
          check_field("status", owed.status, seen.status);
          check_field("frame_id", owed.frame_id, seen.frame_id);
          check_field("payload_byte", owed.payload_byte, seen.payload_byte);
          check_field("byte_index", owed.byte_index, seen.byte_index);
          check_field("payload_count", owed.payload_count, seen.payload_count);
          check_field("last", owed.last, seen.last);
        end
      end
      if (cfg_wr_en) want_id = cfg_wr_data;
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
    end
    fail_count <= errs;
    pending    <= owed_words.size();
    hunting    <= (phase == SEEK);
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// testbench top for crc16_framed_packet_parser_top: clock, reset, byte and frame
// stimulus, receiver back-pressure and the verdict; depends on cfpp_pkg and cfpp_result_checker

module tb;

  localparam int         HALF_PERIOD    = 10;
  localparam int         RX_HOLD_CYCLES = 400;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         DRAIN_CYCLES   = 8;
  localparam logic [7:0] FILL_BYTE      = 8'h00;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_status;
  logic [7:0] out_frame_id;
  logic [7:0] out_payload_byte;
  logic [3:0] out_byte_index;
  logic [4:0] out_payload_count;
  logic       out_last;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  int         fail_count;
  int         pending;
  logic       hunting;

  bit         quiet = 1'b0;
  bit         rx_hold_req = 1'b0;
  int         idle_cycles = 0;
  int         n_sent = 0;
  logic [7:0] cur_id = 8'h00;

  always #(HALF_PERIOD) clk = ~clk;

  crc16_framed_packet_parser_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_frame_id      (out_frame_id),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_payload_count (out_payload_count),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  cfpp_result_checker result_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_frame_id      (out_frame_id),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_payload_count (out_payload_count),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .hunting           (hunting)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return cfpp_pkg::START_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] frame_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ cfpp_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [9:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 10'($urandom_range(1, 3));
    if (r < 85) return 10'($urandom_range(4, 8));
    if (r < 93) return 10'($urandom_range(9, 16));
    return cfpp_pkg::LEN_LIMIT_W;
  endfunction

  // hold the word until it is taken
  task automatic offer(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offer(b);
  endtask

  // keep < 0 sends the whole frame, otherwise only its first keep bytes
  task automatic send_frame(input logic [9:0] len, input logic [7:0] id, input bit bad_crc,
                            input int keep);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          n;
    body.push_back(cfpp_pkg::START_BYTE);
    body.push_back({len[1:0], 6'($urandom)});
    body.push_back(len[9:2]);
    body.push_back(id);
    for (n = 1; n < int'(len) && n < cfpp_pkg::LEN_LIMIT; n++) body.push_back(rand_byte());
    crc = 16'h0000;
    foreach (body[i]) crc = frame_crc_step(crc, body[i]);
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    if (keep < 0 || keep > body.size()) keep = body.size();
    for (n = 0; n < keep; n++) send_byte(body[n]);
  endtask

  task automatic write_wanted_id(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cur_id = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // finish any open frame with filler, then wait for every owed word
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!hunting) begin
      offer(FILL_BYTE);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_frames(input int budget);
    int start, r, k;
    start = n_sent;
    while (n_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        send_frame(pick_len(), cur_id, 1'b0, -1);
      end else if (r < 72) begin
        send_frame(pick_len(), cur_id, 1'b1, -1);
      end else if (r < 80) begin
        send_frame(pick_len(), cur_id ^ 8'($urandom_range(1, 255)), 1'b0, -1);
      end else if (r < 88) begin
        case ($urandom_range(0, 3))
          0:       send_frame(10'd0, cur_id, 1'b0, 3);
          1:       send_frame(cfpp_pkg::LEN_LIMIT_W + 10'd1, cur_id, 1'b0, 3);
          2:       send_frame(10'd1023, cur_id, 1'b0, 3);
          default: send_frame(10'($urandom_range(cfpp_pkg::LEN_LIMIT + 2, 1022)), cur_id,
                              1'b0, 3);
        endcase
      end else if (r < 94) begin
        // frame cut short, the next frame runs into it
        send_frame(pick_len(), cur_id, 1'b0, $urandom_range(1, 8));
      end else begin
        for (k = $urandom_range(1, 3); k > 0; k--) send_byte(rand_byte());
      end
    end
  endtask

  // receiver: random ready pattern, or a long hold-off when asked
  initial begin
    int run, gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        run = ($urandom_range(0, 9) == 0 || quiet) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 12);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no word moved for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_wanted_id(8'h00);
    send_byte(8'hFF);                            // not a start byte
    send_frame(10'd0, cur_id, 1'b0, 3);          // zero length
    send_frame(cfpp_pkg::LEN_LIMIT_W + 10'd1, cur_id, 1'b0, 3);
    send_frame(10'd1, 8'h80, 1'b0, 4);           // wrong id
    send_frame(10'd1, cur_id, 1'b0, -1);         // id only, good crc
    send_frame(10'd2, cur_id, 1'b1, -1);         // crc mismatch
    settle();

    write_wanted_id(8'hFF);
    random_frames(45);
    settle();

    // long receiver hold-off while full frames keep coming
    write_wanted_id(8'($urandom));
    rx_hold_req = 1'b1;
    repeat (3) send_frame(cfpp_pkg::LEN_LIMIT_W, cur_id, 1'b0, -1);
    random_frames(25);
    settle();

    write_wanted_id(cfpp_pkg::START_BYTE);
    quiet = 1'b1;
    random_frames(30);
    quiet = 1'b0;
    random_frames(15);
    settle();

    write_wanted_id(8'($urandom));
    random_frames(35);
    settle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/cfpp_pkg.sv
sv/cfpp_ram.sv
sv/cfpp_ctrl.sv
sv/cfpp_dp.sv
sv/crc16_framed_packet_parser_top.sv
bench/cfpp_result_checker.sv
bench/tb.sv
